// File: hw/rtl/ats_pkg.sv
// ats_pkg: shared types and constants for the annealing tour swap engine.
// No dependencies; imported by ats_posmod and anneal_tour_swap_engine.
package ats_pkg;

	localparam int IN_W   = 8;   // width of city, position and tour slot fields
	localparam int CFG_W  = 9;   // city count register width
	localparam int COST_W = 32;
	localparam int THR_W  = 26;
	localparam int CHG_W  = 27;
	localparam int XW     = 40;  // wide signed width for change and candidate math

	localparam logic signed [XW-1:0] CHG_MAX = XW'(67108863);
	localparam logic signed [XW-1:0] CHG_MIN = -XW'(67108864);
	localparam logic signed [XW-1:0] COST_MAX_X = XW'(64'hFFFF_FFFF);

	typedef enum logic [1:0] {
		OP_LOAD_DIST = 2'd0,
		OP_LOAD_TOUR = 2'd1,
		OP_SET_COST  = 2'd2,
		OP_PROPOSE   = 2'd3
	} op_t;

endpackage

// File: hw/rtl/anneal_tour_swap_engine.sv
// anneal_tour_swap_engine: top level, sequencer and cost datapath for swap moves.
// Depends on ats_pkg, ats_ram (tour and distance stores) and ats_posmod.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------------
//  in       | in_valid / in_stall      | op, row_city, col_city, tour_position,
//           |                          | tour_city, load_value, position_a,
//           |                          | position_b, accept_threshold
//  out      | out_valid / out_stall    | accepted, cost_change, candidate_cost,
//           |                          | current_cost, best_cost, new_best
//  cfg      | cfg_write_en             | cfg_write_data (city count)
//
// Steps from acceptance to the next acceptance: a load or set-cost item goes to the
// result load; a proposal runs position reduction, six tour reads, eight distance reads,
// change and decision, two tour writebacks (accepted proposals only), result load and
// idle; the result is valid from the first cycle in which the next item can be accepted.
// Reset sets the costs and city count and idles both channels; memories not cleared.
// One item at a time; a waiting result holds only the final step.
module anneal_tour_swap_engine import ats_pkg::*; #(
	parameter int MAX_CITIES = 256,
	parameter int DIST_BITS  = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write_en,
	input  logic [CFG_W-1:0]        cfg_write_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              op,
	input  logic [IN_W-1:0]         row_city,
	input  logic [IN_W-1:0]         col_city,
	input  logic [IN_W-1:0]         tour_position,
	input  logic [IN_W-1:0]         tour_city,
	input  logic [COST_W-1:0]       load_value,
	input  logic [IN_W-1:0]         position_a,
	input  logic [IN_W-1:0]         position_b,
	input  logic [THR_W-1:0]        accept_threshold,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    accepted,
	output logic signed [CHG_W-1:0] cost_change,
	output logic [COST_W-1:0]       candidate_cost,
	output logic [COST_W-1:0]       current_cost,
	output logic [COST_W-1:0]       best_cost,
	output logic                    new_best
);

	localparam int CW   = $clog2(MAX_CITIES);
	localparam int NW   = $clog2(MAX_CITIES + 1);
	localparam int ADW  = 2 * CW;
	localparam int SUMW = DIST_BITS + 2;
	localparam int SW   = DIST_BITS + 3;
	localparam int RST_CITIES = (MAX_CITIES < 256) ? MAX_CITIES : 256;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_MOD  = 8'b0000_0010,
		S_TOUR = 8'b0000_0100,
		S_DIST = 8'b0000_1000,
		S_CALC = 8'b0001_0000,
		S_DEC  = 8'b0010_0000,
		S_WB   = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t                    state_q;
	logic [2:0]                step_q;
	logic [NW-1:0]             n_q;
	logic [THR_W-1:0]          thr_q;
	logic [CW-1:0]             city_a_q, city_b_q;
	logic [CW-1:0]             t_ia_q, t_ib_q, t_ic_q, t_id_q;
	logic [SUMW-1:0]           old_sum_q, new_sum_q;
	logic signed [CHG_W-1:0]   delta_q;
	logic [COST_W-1:0]         cand_q;
	logic                      acc_q, newbest_q;
	logic [COST_W-1:0]         cost_q, lowest_q;
	logic                      out_valid_q, out_acc_q, out_newbest_q;
	logic signed [CHG_W-1:0]   out_chg_q;
	logic [COST_W-1:0]         out_cand_q, out_cost_q, out_best_q;

	logic                      in_accept;
	op_t                       in_op;
	logic                      mod_done;
	logic [CW-1:0]             pa, pb, ia, ib, ic, id, n_m1;
	logic [CW-1:0]             sw_ia, sw_ib, sw_ic, sw_id;
	logic                      tour_we;
	logic [CW-1:0]             tour_waddr, tour_wdata, tour_ra0, tour_ra1, tr0, tr1;
	logic [ADW-1:0]            dist_ra0, dist_ra1;
	logic [DIST_BITS-1:0]      dr0, dr1;
	logic [SUMW-1:0]           pair_sum;
	logic signed [SW-1:0]      diff;
	logic signed [XW-1:0]      diff_x, cand_x;
	logic [COST_W-1:0]         cand_c;
	logic                      take;
	logic                      out_load;

	function automatic logic [CW-1:0] wrap_city(input logic [IN_W-1:0] v);
		logic [IN_W:0] r;
		r = {1'b0, v};
		for (int k = IN_W - 1; k >= 0; k--) begin
			if (32'(r) >= (32'(MAX_CITIES) << k)) begin
				r = r - (IN_W + 1)'(32'(MAX_CITIES) << k);
			end
		end
		return CW'(r);
	endfunction

	function automatic logic [NW-1:0] clamp_n(input logic [CFG_W-1:0] v);
		logic [NW-1:0] r;
		if (v < CFG_W'(2)) begin
			r = NW'(2);
		end else if (32'(v) > 32'(MAX_CITIES)) begin
			r = NW'(MAX_CITIES);
		end else begin
			r = NW'(v);
		end
		return r;
	endfunction

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign in_op     = op_t'(op);

	ats_posmod #(
		.CW (CW),
		.NW (NW)
	) u_posmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_accept && (in_op == OP_PROPOSE)),
		.pos_a  (position_a),
		.pos_b  (position_b),
		.city_n (n_q),
		.done   (mod_done),
		.red_a  (pa),
		.red_b  (pb)
	);

	// wrap-around neighbors of both positions
	assign n_m1 = CW'(n_q - NW'(1));
	assign ia   = (pa == '0) ? n_m1 : pa - CW'(1);
	assign ib   = (pa == n_m1) ? '0 : pa + CW'(1);
	assign ic   = (pb == '0) ? n_m1 : pb - CW'(1);
	assign id   = (pb == n_m1) ? '0 : pb + CW'(1);

	// neighbor cities as they stand after the swap
	assign sw_ia = (ia == pa) ? city_b_q : (ia == pb) ? city_a_q : t_ia_q;
	assign sw_ib = (ib == pa) ? city_b_q : (ib == pb) ? city_a_q : t_ib_q;
	assign sw_ic = (ic == pa) ? city_b_q : (ic == pb) ? city_a_q : t_ic_q;
	assign sw_id = (id == pa) ? city_b_q : (id == pb) ? city_a_q : t_id_q;

	always_comb begin
		unique case (step_q)
			3'd0: begin
				tour_ra0 = pa;
				tour_ra1 = pb;
				dist_ra0 = {t_ia_q, city_a_q};
				dist_ra1 = {t_ib_q, city_a_q};
			end
			3'd1: begin
				tour_ra0 = ia;
				tour_ra1 = ib;
				dist_ra0 = {t_ic_q, city_b_q};
				dist_ra1 = {t_id_q, city_b_q};
			end
			3'd2: begin
				tour_ra0 = ic;
				tour_ra1 = id;
				dist_ra0 = {sw_ia, city_b_q};
				dist_ra1 = {sw_ib, city_b_q};
			end
			default: begin
				tour_ra0 = ic;
				tour_ra1 = id;
				dist_ra0 = {sw_ic, city_a_q};
				dist_ra1 = {sw_id, city_a_q};
			end
		endcase
	end

	always_comb begin
		if (state_q == S_WB) begin
			tour_we    = 1'b1;
			tour_waddr = (step_q == 3'd0) ? pa : pb;
			tour_wdata = (step_q == 3'd0) ? city_b_q : city_a_q;
		end else begin
			tour_we    = in_accept && (in_op == OP_LOAD_TOUR);
			tour_waddr = wrap_city(tour_position);
			tour_wdata = wrap_city(tour_city);
		end
	end

	ats_ram #(
		.AW (CW),
		.DW (CW)
	) u_tour_ram (
		.clk    (clk),
		.we     (tour_we),
		.waddr  (tour_waddr),
		.wdata  (tour_wdata),
		.raddr0 (tour_ra0),
		.raddr1 (tour_ra1),
		.rdata0 (tr0),
		.rdata1 (tr1)
	);

	ats_ram #(
		.AW (ADW),
		.DW (DIST_BITS)
	) u_dist_ram (
		.clk    (clk),
		.we     (in_accept && (in_op == OP_LOAD_DIST)),
		.waddr  ({wrap_city(row_city), wrap_city(col_city)}),
		.wdata  (load_value[DIST_BITS-1:0]),
		.raddr0 (dist_ra0),
		.raddr1 (dist_ra1),
		.rdata0 (dr0),
		.rdata1 (dr1)
	);

	assign pair_sum = SUMW'(dr0) + SUMW'(dr1);

	// change, saturated to the result width
	assign diff   = signed'(SW'(new_sum_q) - SW'(old_sum_q));
	assign diff_x = XW'(diff);

	assign cand_x = signed'(XW'(cost_q)) + XW'(delta_q);
	always_comb begin
		priority if (cand_x < 0) begin
			cand_c = '0;
		end else if (cand_x > COST_MAX_X) begin
			cand_c = '1;
		end else begin
			cand_c = cand_x[COST_W-1:0];
		end
	end
	assign take = delta_q < signed'({1'b0, thr_q});

	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			n_q         <= NW'(RST_CITIES);
			cost_q      <= '0;
			lowest_q    <= '1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				n_q <= clamp_n(cfg_write_data);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					step_q <= '0;
					if (in_accept) begin
						if (in_op == OP_SET_COST) begin
							cost_q   <= load_value;
							lowest_q <= load_value;
						end
						state_q <= (in_op == OP_PROPOSE) ? S_MOD : S_DONE;
					end
				end
				S_MOD: begin
					if (mod_done) begin
						state_q <= S_TOUR;
					end
				end
				S_TOUR: begin
					if (step_q == 3'd3) begin
						step_q  <= '0;
						state_q <= S_DIST;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_DIST: begin
					if (step_q == 3'd4) begin
						step_q  <= '0;
						state_q <= S_CALC;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_CALC: begin
					state_q <= S_DEC;
				end
				S_DEC: begin
					if (cand_c < lowest_q) begin
						lowest_q <= cand_c;
					end
					if (take) begin
						cost_q  <= cand_c;
						state_q <= S_WB;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_WB: begin
					if (step_q == 3'd1) begin
						step_q  <= '0;
						state_q <= S_DONE;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			thr_q     <= accept_threshold;
			acc_q     <= 1'b0;
			delta_q   <= '0;
			cand_q    <= '0;
			newbest_q <= 1'b0;
		end
		if (state_q == S_TOUR) begin
			unique case (step_q)
				3'd1: begin
					city_a_q <= tr0;
					city_b_q <= tr1;
				end
				3'd2: begin
					t_ia_q <= tr0;
					t_ib_q <= tr1;
				end
				3'd3: begin
					t_ic_q <= tr0;
					t_id_q <= tr1;
				end
				default: begin
				end
			endcase
		end
		if (state_q == S_DIST) begin
			unique case (step_q)
				3'd0: begin
					old_sum_q <= '0;
					new_sum_q <= '0;
				end
				3'd1, 3'd2: old_sum_q <= old_sum_q + pair_sum;
				default:    new_sum_q <= new_sum_q + pair_sum;
			endcase
		end
		if (state_q == S_CALC) begin
			priority if (diff_x > CHG_MAX) begin
				delta_q <= CHG_MAX[CHG_W-1:0];
			end else if (diff_x < CHG_MIN) begin
				delta_q <= CHG_MIN[CHG_W-1:0];
			end else begin
				delta_q <= diff_x[CHG_W-1:0];
			end
		end
		if (state_q == S_DEC) begin
			cand_q    <= cand_c;
			acc_q     <= take;
			newbest_q <= cand_c < lowest_q;
		end
		if (out_load) begin
			out_acc_q     <= acc_q;
			out_chg_q     <= delta_q;
			out_cand_q    <= cand_q;
			out_cost_q    <= cost_q;
			out_best_q    <= lowest_q;
			out_newbest_q <= newbest_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign accepted       = out_acc_q;
	assign cost_change    = out_chg_q;
	assign candidate_cost = out_cand_q;
	assign current_cost   = out_cost_q;
	assign best_cost      = out_best_q;
	assign new_best       = out_newbest_q;

endmodule

// File: hw/rtl/ats_ram.sv
// ats_ram: synchronous RAM, one write port, two registered read ports.
// No dependencies; used for the tour and distance stores.
module ats_ram #(
	parameter int AW = 8,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr0,
	input  logic [AW-1:0] raddr1,
	output logic [DW-1:0] rdata0,
	output logic [DW-1:0] rdata1
);

	localparam int DEPTH = 1 << AW;

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

// File: hw/rtl/ats_posmod.sv
// ats_posmod: reduces two swap positions modulo the city count.
// Restoring remainder, half the quotient bits per cycle. Depends on ats_pkg.
module ats_posmod import ats_pkg::*; #(
	parameter int CW = 8,
	parameter int NW = 9
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [IN_W-1:0] pos_a,
	input  logic [IN_W-1:0] pos_b,
	input  logic [NW-1:0]   city_n,
	output logic            done,
	output logic [CW-1:0]   red_a,
	output logic [CW-1:0]   red_b
);

	localparam int HALF = IN_W / 2;
	localparam int LW   = IN_W + NW;

	logic [IN_W-1:0] ra_q, rb_q;
	logic            busy_q, hi_q, done_q;

	function automatic logic [IN_W-1:0] rem_steps(input logic [IN_W-1:0] r_in,
		input logic [NW-1:0] n, input logic hi);
		logic [IN_W-1:0] r;
		logic [LW-1:0]   s;
		int              k;
		r = r_in;
		for (int i = 0; i < HALF; i++) begin
			k = hi ? (IN_W - 1 - i) : (HALF - 1 - i);
			s = LW'(n) << k;
			if (LW'(r) >= s) begin
				r = IN_W'(LW'(r) - s);
			end
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			hi_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !hi_q;
			if (start) begin
				busy_q <= 1'b1;
				hi_q   <= 1'b1;
			end else if (busy_q) begin
				hi_q   <= 1'b0;
				busy_q <= hi_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ra_q <= pos_a;
			rb_q <= pos_b;
		end else if (busy_q) begin
			ra_q <= rem_steps(ra_q, city_n, hi_q);
			rb_q <= rem_steps(rb_q, city_n, hi_q);
		end
	end

	assign done  = done_q;
	assign red_a = CW'(ra_q);
	assign red_b = CW'(rb_q);

endmodule
